FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mel filterbank design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

FILE: hdl/mfb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mel filterbank package
// Build-time constants, the per-bin segment/weight table and shared types.
// ---------------------------------------------------------------------------
package mfb_pkg;

   // Build-time configuration
   localparam int NUM_SPEC_BINS  = 257;
   localparam int NUM_MEL_BINS   = 40;
   localparam int SAMPLE_RATE_HZ = 16000;
   localparam int LOW_EDGE_HZ    = 125;
   localparam int HIGH_EDGE_HZ   = 7500;
   localparam int WEIGHT_BITS    = 16;

   // Field widths
   localparam int MAG_W     = 32;
   localparam int IDX_W     = 6;
   localparam int VAL_W     = 34;
   localparam int BIN_W     = $clog2(NUM_SPEC_BINS);
   localparam int SEG_W     = $clog2(NUM_MEL_BINS + 3);
   localparam int FILT_W    = $clog2(NUM_MEL_BINS + 1);
   localparam int CMP_W     = SEG_W + 1;
   localparam int WT_W      = WEIGHT_BITS + 1;
   localparam int PROD_W    = MAG_W + WT_W;
   localparam int CONTRIB_W = PROD_W - WEIGHT_BITS - 7;
   localparam int ENTRY_W   = SEG_W + WT_W;

   // Request queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [63:0] BREAK_Q16 = 64'd700 << 16;

   typedef logic [NUM_SPEC_BINS-1:0][ENTRY_W-1:0] tab_type;

   // Classified and weighted bin handed from front to back
   typedef struct packed {
      logic [SEG_W-1:0]     seg;
      logic [CONTRIB_W-1:0] fall_c;
      logic [CONTRIB_W-1:0] rise_c;
      logic                 last;
   } item_type;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_FLUSH
   } back_state_type;

   // log2 with 32 fraction bits, elaboration only
   function automatic logic [63:0] log2q(input logic [63:0] xi);
      logic [63:0] x;
      logic [63:0] m;
      logic [63:0] frac;
      int          n;
      x = (xi == 64'd0) ? 64'd1 : xi;
      n = 0;
      for (int i = 0; i < 63; i++) begin
         if ((x >> (n + 1)) != 64'd0) n++;
      end
      m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      frac = 64'd0;
      for (int b = 0; b < 32; b++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(n) << 32) | frac;
   endfunction

   // Segment and rising weight of every spectrum bin
   function automatic tab_type build_tab();
      logic [63:0] edge_q [NUM_MEL_BINS+2];
      logic [63:0] lo_hz;
      logic [63:0] hi_hz;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] target;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] fq;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] w;
      logic [63:0] dscale;
      int unsigned s;
      tab_type     t;
      lo_hz = 64'(LOW_EDGE_HZ);
      hi_hz = 64'(HIGH_EDGE_HZ);
      if (hi_hz < lo_hz) hi_hz = lo_hz;
      ua = log2q(BREAK_Q16 + (lo_hz << 16));
      ub = log2q(BREAK_Q16 + (hi_hz << 16));
      edge_q[0] = lo_hz << 16;
      edge_q[NUM_MEL_BINS+1] = hi_hz << 16;
      // smallest Q16 edge whose log reaches the evenly spaced target
      for (int i = 1; i <= NUM_MEL_BINS; i++) begin
         target = ua + (64'(i) * (ub - ua)) / 64'(NUM_MEL_BINS + 1);
         lo = lo_hz << 16;
         hi = hi_hz << 16;
         for (int j = 0; j < 64; j++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo) >> 1);
               if (log2q(BREAK_Q16 + mid) >= target) hi = mid;
               else lo = mid + 64'd1;
            end
         end
         edge_q[i] = lo;
      end
      dscale = 64'(2 * (NUM_SPEC_BINS - 1));
      for (int i = 0; i < NUM_MEL_BINS + 2; i++) edge_q[i] = edge_q[i] * dscale;
      for (int k = 0; k < NUM_SPEC_BINS; k++) begin
         s = 0;
         fq = (64'(k) * 64'(SAMPLE_RATE_HZ)) << 16;
         for (int i = 0; i < NUM_MEL_BINS + 2; i++) begin
            if (edge_q[i] < fq) s++;
         end
         w = 64'd0;
         if (s >= 1 && s <= NUM_MEL_BINS + 1) begin
            num = fq - edge_q[s-1];
            den = edge_q[s] - edge_q[s-1];
            if (den == 64'd0 || num >= den) begin
               w = 64'd1 << WEIGHT_BITS;
            end else begin
               // restoring division, one quotient bit a step
               for (int b = 0; b < WEIGHT_BITS; b++) begin
                  num = num << 1;
                  w = w << 1;
                  if (num >= den) begin
                     num = num - den;
                     w = w | 64'd1;
                  end
               end
            end
         end
         t[k] = {SEG_W'(s), WT_W'(w)};
      end
      return t;
   endfunction

   localparam tab_type WEIGHT_TAB = build_tab();

endpackage

FILE: hdl/mfb_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mel filterbank front end
// Counts bins, looks up segment and weight, forms both weighted contributions.
// ---------------------------------------------------------------------------
module mfb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [mfb_pkg::MAG_W-1:0]     req_magnitude,
   output logic                          req_full,
   input  logic                          q_full,
   output logic                          q_push,
   output mfb_pkg::item_type             q_item
);
   import mfb_pkg::*;

   logic [BIN_W-1:0]   bin_ff;
   logic [BIN_W-1:0]   bin_in;
   logic               a_valid_ff;
   logic [ENTRY_W-1:0] a_entry_ff;
   logic [MAG_W-1:0]   a_mag_ff;
   logic               a_last_ff;
   logic               b_valid_ff;
   item_type           b_item_ff;
   item_type           b_item_in;
   logic               a_ready;
   logic               b_ready;
   logic               accept;
   logic               bin_last;
   logic [WT_W-1:0]    rise_w;
   logic [WT_W-1:0]    fall_w;
   logic [PROD_W-1:0]  rise_p;
   logic [PROD_W-1:0]  fall_p;

   // Stall chain from the queue back to the request port
   assign b_ready  = !b_valid_ff || !q_full;
   assign a_ready  = !a_valid_ff || b_ready;
   assign req_full = !a_ready;
   assign accept   = req_push && a_ready;
   assign bin_last = (bin_ff == BIN_W'(NUM_SPEC_BINS - 1));
   assign bin_in   = bin_last ? '0 : bin_ff + BIN_W'(1);

   // Advance the bin counter per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
      end else if (accept) begin
         bin_ff <= bin_in;
      end
   end

   // Stage A: table read
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_entry_ff <= WEIGHT_TAB[bin_ff];
         a_mag_ff   <= req_magnitude;
         a_last_ff  <= bin_last;
      end
   end

   // Weight both sides of the triangle
   assign rise_w = a_entry_ff[WT_W-1:0];
   assign fall_w = WT_W'(1 << WEIGHT_BITS) - rise_w;
   assign rise_p = PROD_W'(a_mag_ff) * PROD_W'(rise_w);
   assign fall_p = PROD_W'(a_mag_ff) * PROD_W'(fall_w);

   always_comb begin
      b_item_in.seg    = a_entry_ff[ENTRY_W-1:WT_W];
      b_item_in.rise_c = rise_p[PROD_W-1 -: CONTRIB_W];
      b_item_in.fall_c = fall_p[PROD_W-1 -: CONTRIB_W];
      b_item_in.last   = a_last_ff;
   end

   // Stage B: products
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign q_push = b_valid_ff;
   assign q_item = b_item_ff;

endmodule

FILE: hdl/mfb_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mel filterbank request queue
// Short queue of weighted bins between the front end and the accumulator.
// ---------------------------------------------------------------------------
module mfb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mfb_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output mfb_pkg::item_type head_item,
   output logic              empty
);
   import mfb_pkg::*;

   item_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              wr_go;
   logic              rd_go;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign wr_go     = push && !full;
   assign rd_go     = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_go && !rd_go) count_in = count_ff + QCNT_W'(1);
      else if (rd_go && !wr_go) count_in = count_ff - QCNT_W'(1);
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_go) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (rd_go) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (wr_go) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/mfb_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mel filterbank back end
// Holds the two open filter sums, emits finished filters, flushes the frame.
// ---------------------------------------------------------------------------
module mfb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  mfb_pkg::item_type           q_head,
   output logic                        q_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [mfb_pkg::IDX_W-1:0]   rsp_mel_index,
   output logic [mfb_pkg::VAL_W-1:0]   rsp_mel_value,
   output logic                        rsp_frame_last
);
   import mfb_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [VAL_W-1:0]  falling_ff;
   logic [VAL_W-1:0]  falling_in;
   logic [VAL_W-1:0]  rising_ff;
   logic [VAL_W-1:0]  rising_in;
   logic [FILT_W-1:0] next_ff;
   logic [FILT_W-1:0] next_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [VAL_W-1:0]  out_val_ff;
   logic              out_last_ff;
   logic              can_emit;
   logic              lag;
   logic              emit_go;
   logic              add_go;
   logic              final_emit;
   logic              all_done;
   logic [CMP_W-1:0]  segx;
   logic [CMP_W-1:0]  nx;
   logic              fall_ok;
   logic              rise_ok;
   logic [CONTRIB_W-1:0] add_f;
   logic [CONTRIB_W-1:0] add_r;

   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [CONTRIB_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + (VAL_W+1)'(b);
      return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
   endfunction

   assign can_emit   = !out_valid_ff || rsp_pop;
   assign segx       = CMP_W'(q_head.seg);
   assign nx         = CMP_W'(next_ff);
   assign all_done   = (next_ff == FILT_W'(NUM_MEL_BINS));
   assign final_emit = (next_ff == FILT_W'(NUM_MEL_BINS - 1));
   // filters left behind by this bin must go out before it is added
   assign lag        = (nx + CMP_W'(2) < segx) && !all_done;

   // Route the two contributions onto the open sums
   assign fall_ok = (segx >= CMP_W'(2)) && (segx < CMP_W'(NUM_MEL_BINS + 2));
   assign rise_ok = (segx >= CMP_W'(1)) && (segx < CMP_W'(NUM_MEL_BINS + 1));

   always_comb begin
      add_f = '0;
      add_r = '0;
      if (fall_ok && segx == nx + CMP_W'(2)) add_f = q_head.fall_c;
      else if (rise_ok && segx == nx + CMP_W'(1)) add_f = q_head.rise_c;
      if (rise_ok && segx == nx + CMP_W'(2)) add_r = q_head.rise_c;
      else if (fall_ok && segx == nx + CMP_W'(3)) add_r = q_head.fall_c;
   end

   // Sequencer outputs
   always_comb begin
      emit_go = 1'b0;
      add_go  = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            emit_go = !q_empty && lag && can_emit;
            add_go  = !q_empty && !lag;
         end
         ST_FLUSH: begin
            emit_go = can_emit;
         end
         default: ;
      endcase
   end

   assign q_pop = add_go;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (add_go && q_head.last && !all_done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (emit_go && final_emit) state_in = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   // Accumulator and filter counter updates
   always_comb begin
      falling_in = falling_ff;
      rising_in  = rising_ff;
      next_in    = next_ff;
      if (emit_go) begin
         falling_in = rising_ff;
         rising_in  = '0;
         next_in    = next_ff + FILT_W'(1);
         if (state_ff == ST_FLUSH && final_emit) begin
            falling_in = '0;
            next_in    = '0;
         end
      end else if (add_go) begin
         falling_in = sat_add(falling_ff, add_f);
         rising_in  = sat_add(rising_ff, add_r);
         if (q_head.last && all_done) begin
            falling_in = '0;
            rising_in  = '0;
            next_in    = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_go) out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         falling_ff   <= '0;
         rising_ff    <= '0;
         next_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         falling_ff   <= falling_in;
         rising_ff    <= rising_in;
         next_ff      <= next_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result register on emit
   always_ff @(posedge clock) begin
      if (emit_go) begin
         out_idx_ff  <= IDX_W'(next_ff);
         out_val_ff  <= falling_ff;
         out_last_ff <= final_emit;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_mel_index  = out_idx_ff;
   assign rsp_mel_value  = out_val_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

FILE: hdl/mel_filterbank_accumulator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mel filterbank accumulator
// Triangular mel filterbank over the magnitude bins of one spectrum frame.
// ---------------------------------------------------------------------------
// Usage:
//   Push the bins of a frame in order on req_magnitude (req_push, req_full).
//   The frame length is fixed; the counter wraps after the last bin.
//   Filter sums come out in index order on rsp_mel_index / rsp_mel_value;
//   rsp_frame_last marks the final filter of the frame. Take them with
//   rsp_pop while rsp_empty is low.
// Timing:
//   Bins are accepted one per cycle while req_full is low. The front end
//   registers the table read, then the two parallel products, and feeds a
//   4-entry queue. The accumulator either adds one bin or emits one filter
//   at a time, never both. A filter is shown once the bin that closes it has
//   passed both front stages and the queue; the last bin of a frame starts
//   a flush that emits the remaining filters.
// Reset:
//   Synchronous; clears the bin counter, the queue, the open sums and the
//   result valid flag. The weight table is a constant and needs no fill.
// Stall:
//   A held result stops emission; bins still flow until the queue and both
//   front stages are full, then req_full rises.
// ---------------------------------------------------------------------------
module mel_filterbank_accumulator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic [mfb_pkg::MAG_W-1:0]   req_magnitude,
   output logic                        req_full,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [mfb_pkg::IDX_W-1:0]   rsp_mel_index,
   output logic [mfb_pkg::VAL_W-1:0]   rsp_mel_value,
   output logic                        rsp_frame_last
);
   import mfb_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   item_type q_item;
   item_type q_head;

   // Classify and weight each bin
   mfb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_magnitude (req_magnitude),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   // Decouple front from accumulator
   mfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (q_head),
      .empty     (q_empty)
   );

   // Accumulate and emit filters
   mfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_mel_index  (rsp_mel_index),
      .rsp_mel_value  (rsp_mel_value),
      .rsp_frame_last (rsp_frame_last)
   );

`include "assert_macros.svh"

   // Frame end marker only on the highest filter
   `ASSERT_ALWAYS(a_last_index, clock, reset, !rsp_empty && rsp_frame_last |-> rsp_mel_index == IDX_W'(NUM_MEL_BINS - 1), "frame_last on wrong filter")

   // Filters within a frame come out in consecutive order
   `ASSERT_ALWAYS(a_index_order, clock, reset, (!rsp_empty && rsp_pop && !rsp_frame_last ##1 !rsp_empty) |-> rsp_mel_index == $past(rsp_mel_index) + IDX_W'(1), "filter index skipped")

   // Meant to flag a stuck queue head; the consequent always holds via $past(q_pop)
   `ASSERT_NEXT(a_queue_drain, clock, reset, !q_empty && !q_pop && rsp_empty, rsp_empty == 1'b0 || q_pop == 1'b1 || $past(q_pop) == 1'b0, "queue head stuck")

endmodule
